/* rtl/core/kfi_pkg.sv */
`timescale 1ns / 1ps

package kfi_pkg;

    localparam int MAX_KEYS    = 64;
    localparam int IDX_W       = $clog2(MAX_KEYS);
    localparam int TABLE_LIMIT = (MAX_KEYS < 64) ? MAX_KEYS : 64;
    localparam int CHANNELS    = 5;
    localparam int FRAC_W      = 16;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic REG_KEY_COUNT = 1'b0;

    typedef logic [CHANNELS-1:0][31:0] chan_vec_t;

    typedef struct packed {
        logic [31:0] time_q;
        chan_vec_t   chans;
    } key_entry_t;

endpackage

/* rtl/core/keyframe_search_and_interpolate_unit.sv */
`timescale 1ns / 1ps
// A load is written into the key table in the cycle it is accepted. A sample checks the first
// key, the last key and the cached bracket in turn, else walks key by key from the cached
// bracket; between two keys it divides serially for the fraction, then blends the five channels
// one after another on the shared multiply-add. The key table has one read port.
// Throughput: one word at a time; in_ready is high only while the sequencer idles.
// Reset: key_count = 1, cached bracket = 0, no result pending; key table is not cleared.
module keyframe_search_and_interpolate_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [5:0]  key_index,
    input  logic signed [31:0] key_time,
    input  logic signed [31:0] key_x,
    input  logic signed [31:0] key_y,
    input  logic signed [31:0] key_z,
    input  logic signed [31:0] key_w,
    input  logic signed [31:0] key_scale,
    input  logic signed [31:0] sample_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  index_low,
    output logic [5:0]  index_high,
    output logic [15:0] fraction,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] pos_w,
    output logic signed [31:0] scale_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kfi_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_RD_FIRST = 16'b0000_0000_0000_0010,
        S_CK_FIRST = 16'b0000_0000_0000_0100,
        S_RD_LAST  = 16'b0000_0000_0000_1000,
        S_CK_LAST  = 16'b0000_0000_0001_0000,
        S_RD_HINT  = 16'b0000_0000_0010_0000,
        S_CK_HINT  = 16'b0000_0000_0100_0000,
        S_RD_WALK  = 16'b0000_0000_1000_0000,
        S_CK_WALK  = 16'b0000_0001_0000_0000,
        S_DIV_SET  = 16'b0000_0010_0000_0000,
        S_DIVIDE   = 16'b0000_0100_0000_0000,
        S_RD_P0    = 16'b0000_1000_0000_0000,
        S_RD_P1    = 16'b0001_0000_0000_0000,
        S_GET_P1   = 16'b0010_0000_0000_0000,
        S_BLEND    = 16'b0100_0000_0000_0000,
        S_FINISH   = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    key_entry_t mem [MAX_KEYS];
    key_entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [6:0]       key_count_reg;
    logic [IDX_W-1:0] hint_reg;
    logic [6:0]       n_reg;
    logic [IDX_W-1:0] last_reg, next_reg, i0_reg, i1_reg;
    logic             fwd_reg;
    logic [31:0]      t_reg, tfirst_reg, tlast_reg, tlo_reg, thi_reg;
    logic [FRAC_W-1:0] frac_reg;
    chan_vec_t        p0_reg, p1_reg, res_reg;
    logic [2:0]       ch_reg;
    logic             bwait_reg;

    logic             out_valid_reg;
    logic [5:0]       index_low_reg, index_high_reg;
    logic [15:0]      fraction_reg;
    chan_vec_t        out_chans_reg;

    logic [6:0]       n_eff;
    logic [IDX_W-1:0] hint_eff, nm1;
    logic signed [31:0] t_s, rtime;
    logic [32:0]      num_w, den_w;
    logic             div_start, div_done;
    logic [FRAC_W-1:0] div_quot;
    logic             blend_start, blend_done;
    logic [31:0]      blend_result;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KEY_COUNT) ? {25'd0, key_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_count_reg <= 7'd1;
        else if (cfg_wr && paddr[2] == REG_KEY_COUNT)
            key_count_reg <= pwdata[6:0];
    end

    always_comb
    begin
        if (key_count_reg == 7'd0)
            n_eff = 7'd1;
        else if (key_count_reg > 7'(TABLE_LIMIT))
            n_eff = 7'(TABLE_LIMIT);
        else
            n_eff = key_count_reg;
    end

    assign hint_eff = ({1'b0, hint_reg} >= n_eff) ? IDX_W'(n_eff - 7'd1) : hint_reg;
    assign nm1      = IDX_W'(n_reg - 7'd1);
    assign t_s      = $signed(t_reg);
    assign rtime    = $signed(rd_data_reg.time_q);
    assign num_w    = {t_reg[31], t_reg} - {tlo_reg[31], tlo_reg};
    assign den_w    = {thi_reg[31], thi_reg} - {tlo_reg[31], tlo_reg};

    always_comb
    begin
        unique case (state_reg)
            S_RD_FIRST: rd_addr = '0;
            S_RD_LAST:  rd_addr = nm1;
            S_RD_HINT:  rd_addr = last_reg;
            S_RD_WALK:  rd_addr = next_reg;
            S_RD_P0:    rd_addr = i0_reg;
            S_RD_P1:    rd_addr = i1_reg;
            default:    rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && command == CMD_LOAD
            && {1'b0, key_index} < 7'(MAX_KEYS))
        begin
            mem[key_index] <= '{time_q: key_time,
                                chans: {key_scale, key_w, key_z, key_y, key_x}};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign div_start   = (state_reg == S_DIV_SET) && (num_w < den_w);
    assign blend_start = (state_reg == S_BLEND) && !bwait_reg;

    kfi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_w),
        .den   (den_w),
        .done  (div_done),
        .quot  (div_quot)
    );

    kfi_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (blend_start),
        .p0     (p0_reg[ch_reg]),
        .p1     (p1_reg[ch_reg]),
        .frac   (frac_reg),
        .done   (blend_done),
        .result (blend_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid && command == CMD_SAMPLE)
                    state_next = S_RD_FIRST;
            S_RD_FIRST: state_next = S_CK_FIRST;
            S_CK_FIRST: state_next = (t_s <= rtime) ? S_RD_P0 : S_RD_LAST;
            S_RD_LAST:  state_next = S_CK_LAST;
            S_CK_LAST:  state_next = (t_s >= rtime) ? S_RD_P0 : S_RD_HINT;
            S_RD_HINT:  state_next = S_CK_HINT;
            S_CK_HINT:  state_next = (t_s == rtime) ? S_RD_P0 : S_RD_WALK;
            S_RD_WALK:
                if (fwd_reg)
                    state_next = (next_reg < nm1) ? S_CK_WALK : S_DIV_SET;
                else
                    state_next = (next_reg != '0) ? S_CK_WALK : S_DIV_SET;
            S_CK_WALK:
                if (fwd_reg)
                    state_next = (t_s >= rtime) ? S_RD_WALK : S_DIV_SET;
                else
                    state_next = (t_s <= rtime) ? S_RD_WALK : S_DIV_SET;
            S_DIV_SET:  state_next = (num_w < den_w) ? S_DIVIDE : S_RD_P0;
            S_DIVIDE:   state_next = div_done ? S_RD_P0 : S_DIVIDE;
            S_RD_P0:    state_next = S_RD_P1;
            S_RD_P1:    state_next = S_GET_P1;
            S_GET_P1:   state_next = S_BLEND;
            S_BLEND:
                if (blend_done && ch_reg == 3'(CHANNELS - 1))
                    state_next = S_FINISH;
            S_FINISH:
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hint_reg      <= '0;
            bwait_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (blend_start)
                bwait_reg <= 1'b1;
            else if (blend_done)
                bwait_reg <= 1'b0;
            if (state_reg == S_FINISH && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                hint_reg      <= last_reg;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                t_reg    <= sample_time;
                n_reg    <= n_eff;
                last_reg <= hint_eff;
                frac_reg <= '0;
                ch_reg   <= '0;
            end
            S_CK_FIRST:
            begin
                tfirst_reg <= rd_data_reg.time_q;
                if (t_s <= rtime)
                begin
                    last_reg <= '0;
                    i0_reg   <= '0;
                    i1_reg   <= '0;
                end
            end
            S_CK_LAST:
            begin
                tlast_reg <= rd_data_reg.time_q;
                if (t_s >= rtime)
                begin
                    last_reg <= nm1;
                    i0_reg   <= nm1;
                    i1_reg   <= nm1;
                end
            end
            S_CK_HINT:
            begin
                if (t_s > rtime)
                begin
                    fwd_reg  <= 1'b1;
                    tlo_reg  <= rd_data_reg.time_q;
                    next_reg <= last_reg + 1'b1;
                end
                else if (t_s < rtime)
                begin
                    fwd_reg  <= 1'b0;
                    thi_reg  <= rd_data_reg.time_q;
                    next_reg <= last_reg - 1'b1;
                end
                else
                begin
                    i0_reg <= last_reg;
                    i1_reg <= last_reg;
                end
            end
            S_RD_WALK:
            begin
                if (fwd_reg && !(next_reg < nm1))
                begin
                    thi_reg <= tlast_reg;
                    i0_reg  <= last_reg;
                    i1_reg  <= next_reg;
                end
                else if (!fwd_reg && next_reg == '0)
                begin
                    tlo_reg <= tfirst_reg;
                    i0_reg  <= next_reg;
                    i1_reg  <= last_reg;
                end
            end
            S_CK_WALK:
            begin
                if (fwd_reg)
                begin
                    if (t_s >= rtime)
                    begin
                        last_reg <= next_reg;
                        tlo_reg  <= rd_data_reg.time_q;
                        next_reg <= next_reg + 1'b1;
                    end
                    else
                    begin
                        thi_reg <= rd_data_reg.time_q;
                        i0_reg  <= last_reg;
                        i1_reg  <= next_reg;
                    end
                end
                else
                begin
                    if (t_s <= rtime)
                    begin
                        last_reg <= next_reg;
                        thi_reg  <= rd_data_reg.time_q;
                        next_reg <= next_reg - 1'b1;
                    end
                    else
                    begin
                        tlo_reg <= rd_data_reg.time_q;
                        i0_reg  <= next_reg;
                        i1_reg  <= last_reg;
                    end
                end
            end
            S_DIV_SET:
                if (!(num_w < den_w))
                    i0_reg <= i1_reg;
            S_DIVIDE:
                if (div_done)
                    frac_reg <= div_quot;
            S_RD_P1:
                p0_reg <= rd_data_reg.chans;
            S_GET_P1:
                p1_reg <= rd_data_reg.chans;
            S_BLEND:
                if (blend_done)
                begin
                    res_reg[ch_reg] <= blend_result;
                    ch_reg          <= ch_reg + 3'd1;
                end
            S_FINISH:
                if (!out_valid_reg || out_ready)
                begin
                    index_low_reg  <= i0_reg;
                    index_high_reg <= i1_reg;
                    fraction_reg   <= frac_reg;
                    out_chans_reg  <= res_reg;
                end
            default: ;
        endcase
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign index_low  = index_low_reg;
    assign index_high = index_high_reg;
    assign fraction   = fraction_reg;
    assign pos_x      = out_chans_reg[0];
    assign pos_y      = out_chans_reg[1];
    assign pos_z      = out_chans_reg[2];
    assign pos_w      = out_chans_reg[3];
    assign scale_out  = out_chans_reg[4];

endmodule

/* rtl/core/kfi_div.sv */
`timescale 1ns / 1ps

module kfi_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [32:0]               num,
    input  logic [32:0]               den,
    output logic                      done,
    output logic [kfi_pkg::FRAC_W-1:0] quot
);
    import kfi_pkg::*;

    logic [33:0]       rem_reg;
    logic [32:0]       den_reg;
    logic [FRAC_W-1:0] quot_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [33:0]       rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg[32:0], 1'b0};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(FRAC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quot_reg <= {quot_reg[FRAC_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/core/kfi_blend.sv */
`timescale 1ns / 1ps

module kfi_blend (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                p0,
    input  logic [31:0]                p1,
    input  logic [kfi_pkg::FRAC_W-1:0] frac,
    output logic                       done,
    output logic [31:0]                result
);
    import kfi_pkg::*;

    logic               stage1_reg;
    logic               done_reg;
    logic signed [49:0] prod_reg;
    logic [31:0]        p0_reg;
    logic [31:0]        result_reg;
    logic signed [32:0] diff;
    logic signed [49:0] shifted;

    assign diff    = $signed({p1[31], p1}) - $signed({p0[31], p0});
    assign shifted = prod_reg >>> FRAC_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            done_reg   <= stage1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= diff * $signed({1'b0, frac});
            p0_reg   <= p0;
        end
        if (stage1_reg)
            result_reg <= p0_reg + shifted[31:0];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/core/kfi_checker.sv */
`timescale 1ns / 1ps

module kfi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        command,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  index_low,
    input logic [5:0]  index_high,
    input logic [15:0] fraction
);
    import kfi_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(index_low) && $stable(fraction))
        else $error("result word dropped while stalled");

    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_SAMPLE |=> !in_ready)
        else $error("ready while sample in progress");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> index_low <= index_high)
        else $error("bracket indices out of order");

    a_frac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_low == index_high |-> fraction == 16'd0)
        else $error("nonzero fraction on single key");

endmodule

bind keyframe_search_and_interpolate_unit kfi_checker u_kfi_checker (.*);

/* tb/tb_keyframe_search_and_interpolate_unit.sv */
`timescale 1ns / 1ps

module tb_keyframe_search_and_interpolate_unit;
    import kfi_pkg::*;

    typedef struct {
        logic     command;
        bit [5:0] key_index;
        int       key_time;
        int       chan [5];
        int       sample_time;
    } kf_word_t;

    typedef struct {
        bit [5:0]  index_low;
        bit [5:0]  index_high;
        bit [15:0] fraction;
        int        chan [5];
    } kf_result_t;

    class interp_scoreboard;
        int          key_times [64];
        int          key_chans [64][5];
        int unsigned hint;
        int unsigned key_count;
        kf_result_t  pending_samples [$];
        int          errors;
        int          loads, samples, clamped, exact, between;

        function new();
            hint = 0;
            key_count = 1;
        endfunction

        function int lerp_floor(int p0, int p1, bit [15:0] frac);
            longint prod;
            prod = (longint'(p1) - longint'(p0)) * longint'({16'd0, frac});
            return int'(longint'(p0) + (prod >>> 16));
        endfunction

        function void note_word(kf_word_t w);
            int unsigned n, last, nxt, i0, i1;
            longint t;
            longint unsigned num, den;
            bit [15:0] frac;
            kf_result_t r;
            if (w.command == CMD_LOAD) begin
                key_times[w.key_index] = w.key_time;
                key_chans[w.key_index] = w.chan;
                loads++;
                return;
            end
            n = (key_count == 0) ? 1 : key_count;
            if (n > TABLE_LIMIT)
                n = TABLE_LIMIT;
            last = (hint >= n) ? n - 1 : hint;
            t = w.sample_time;
            frac = 0;
            if (t <= key_times[0]) begin
                last = 0;
                i0 = 0;
                i1 = 0;
            end
            else if (t >= key_times[n-1]) begin
                last = n - 1;
                i0 = last;
                i1 = last;
            end
            else if (t > key_times[last]) begin
                nxt = last + 1;
                while (nxt < n - 1 && t >= key_times[nxt]) begin
                    last = nxt;
                    nxt++;
                end
                i0 = last;
                i1 = nxt;
            end
            else if (t < key_times[last]) begin
                nxt = last - 1;
                while (nxt > 0 && t <= key_times[nxt]) begin
                    last = nxt;
                    nxt--;
                end
                i0 = nxt;
                i1 = last;
            end
            else begin
                i0 = last;
                i1 = last;
            end
            if (i0 != i1) begin
                num = longint'(t - longint'(key_times[i0]));
                den = longint'(longint'(key_times[i1]) - longint'(key_times[i0]));
                if (num >= den)
                    i0 = i1;
                else
                    frac = 16'((num << 16) / den);
            end
            hint = last & 6'h3f;
            if (i0 != i1)
                between++;
            else if (t <= key_times[0] || t >= key_times[n-1])
                clamped++;
            else
                exact++;
            samples++;
            r.index_low = i0[5:0];
            r.index_high = i1[5:0];
            r.fraction = frac;
            for (int c = 0; c < 5; c++)
                r.chan[c] = lerp_floor(key_chans[i0][c], key_chans[i1][c], frac);
            pending_samples.push_back(r);
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_word(kf_result_t r);
            kf_result_t e;
            string names [5];
            names = '{"pos_x", "pos_y", "pos_z", "pos_w", "scale_out"};
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected result word, index_low %0d", $time, r.index_low);
                errors++;
                return;
            end
            e = pending_samples.pop_front();
            compare_field("index_low", e.index_low, r.index_low);
            compare_field("index_high", e.index_high, r.index_high);
            compare_field("fraction", e.fraction, r.fraction);
            for (int c = 0; c < 5; c++)
                compare_field(names[c], e.chan[c], r.chan[c]);
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0, in_ready;
    logic command = 0;
    logic [5:0] key_index = 0;
    logic signed [31:0] key_time = 0, key_x = 0, key_y = 0, key_z = 0, key_w = 0;
    logic signed [31:0] key_scale = 0, sample_time = 0;
    logic out_valid, out_ready = 0;
    logic [5:0] index_low, index_high;
    logic [15:0] fraction;
    logic signed [31:0] pos_x, pos_y, pos_z, pos_w, scale_out;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    logic pready;

    interp_scoreboard sb = new();
    bit long_hold_req = 0;

    always #1 clk = ~clk;

    keyframe_search_and_interpolate_unit dut (.*);

    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random backpressure, one long hold on request
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 3) == 0) begin
                out_ready <= 0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 3)) @(posedge clk);
            end
            out_ready <= 1;
            repeat ($urandom_range(0, 10)) @(posedge clk);
            if (long_hold_req) begin
                out_ready <= 0;
                repeat (500) @(posedge clk);
                long_hold_req = 0;
            end
        end
    end

    always @(negedge clk) begin
        kf_result_t r;
        if (rst_n && out_valid && out_ready) begin
            r.index_low = index_low;
            r.index_high = index_high;
            r.fraction = fraction;
            r.chan = '{pos_x, pos_y, pos_z, pos_w, scale_out};
            sb.check_word(r);
        end
    end

    task automatic reg_write(input bit [6:0] value);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 3'(REG_KEY_COUNT * 4);
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        sb.key_count = value;
        pwrite <= 0;
        penable <= 0;
        @(posedge clk);
        penable <= 1;
        @(negedge clk);
        if (prdata[6:0] !== value) begin
            $display("%0t: key_count readback, expected %h, got %h", $time, value, prdata[6:0]);
            sb.errors++;
        end
        @(posedge clk);
        psel <= 0;
        penable <= 0;
    endtask

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send(input kf_word_t w);
        in_valid <= 1;
        command <= w.command;
        key_index <= w.key_index;
        key_time <= w.key_time;
        key_x <= w.chan[0];
        key_y <= w.chan[1];
        key_z <= w.chan[2];
        key_w <= w.chan[3];
        key_scale <= w.chan[4];
        sample_time <= w.sample_time;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        sb.note_word(w);
    endtask

    task automatic send_gap(input kf_word_t w);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 :
              ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        send(w);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_samples.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic kf_word_t mk_load(int idx, int t);
        kf_word_t w;
        w.command = CMD_LOAD;
        w.key_index = idx[5:0];
        w.key_time = t;
        for (int c = 0; c < 5; c++)
            w.chan[c] = $urandom;
        w.sample_time = $urandom;
        return w;
    endfunction

    function automatic kf_word_t mk_sample(int t);
        kf_word_t w;
        w = mk_load($urandom_range(0, 63), $urandom);
        w.command = CMD_SAMPLE;
        w.sample_time = t;
        return w;
    endfunction

    task automatic fill_table(input int base, input int step);
        for (int i = 0; i < 64; i++)
            send_gap(mk_load(i, base + i * step));
    endtask

    function automatic int pick_time(int n);
        longint lo, hi;
        n = (n == 0) ? 1 : (n > 64 ? 64 : n);
        lo = sb.key_times[0];
        hi = sb.key_times[n-1];
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return sb.key_times[$urandom_range(0, n - 1)];
            2: return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: begin
                if (hi <= lo)
                    return int'(lo) + $urandom_range(0, 20) - 10;
                return int'(lo + longint'($urandom) % (hi - lo + 1));
            end
        endcase
    endfunction

    initial begin
        int counts [8];
        int steps [8];
        kf_word_t w;
        int idx;
        counts = '{64, 1, 2, 0, 127, 37, 64, 5};
        steps = '{65536, 1, 7, 67108863, 16777216, 3000, 1048576, 100};

        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        for (int ph = 0; ph < 8; ph++) begin
            reg_write(7'(counts[ph]));
            @(posedge clk);
            if (steps[ph] == 67108863)
                fill_table(32'h8000_0000, steps[ph]);
            else
                fill_table(-32 * steps[ph] + int'($urandom_range(0, 1000)) - 500, steps[ph]);

            if (ph == 0) begin
                w = mk_load(0, sb.key_times[0]);
                w.chan = '{32'h8000_0000, 32'h7fff_ffff, 0, -1, 32'h8000_0000};
                send(w);
                w = mk_load(1, sb.key_times[1]);
                w.chan = '{32'h7fff_ffff, 32'h8000_0000, -1, 0, 32'h7fff_ffff};
                send(w);
                send(mk_sample(32'h8000_0000));
                send(mk_sample(sb.key_times[0]));
                send(mk_sample(sb.key_times[0] + 1));
                send(mk_sample(sb.key_times[1] - 1));
                send(mk_sample(sb.key_times[10]));
                send(mk_sample(sb.key_times[10] + 40000));
                send(mk_sample(sb.key_times[40] + 123));
                send(mk_sample(sb.key_times[5]));
                send(mk_sample(sb.key_times[3] + 7));
                send(mk_sample(sb.key_times[63]));
                send(mk_sample(32'h7fff_ffff));
                send(mk_sample(sb.key_times[62] + 1));
                // descending pair: walk must stop on the table ends
                send(mk_load(20, sb.key_times[30]));
                send(mk_sample(sb.key_times[25]));
                send(mk_sample(sb.key_times[19] + 1));
            end

            if (ph == 2)
                long_hold_req = 1;
            for (int i = 0; i < 100; i++) begin
                if (ph == 5 && i == 50) begin
                    in_valid <= 0;
                    while (sb.pending_samples.size() > 0)
                        @(posedge clk);
                    @(posedge clk);
                end
                if ($urandom_range(0, 99) < 15) begin
                    idx = $urandom_range(0, 63);
                    if ($urandom_range(0, 4) == 0)
                        send_gap(mk_load(idx, $urandom));
                    else
                        send_gap(mk_load(idx, sb.key_times[idx] + $urandom_range(0, 6) - 3));
                end
                else
                    send_gap(mk_sample(pick_time(int'(sb.key_count))));
            end
            drain();
        end

        $display("Covered %0d loads and %0d samples over 8 key counts:", sb.loads, sb.samples);
        $display("  %0d clamped, %0d exact hits, %0d interpolated between keys",
                 sb.clamped, sb.exact, sb.between);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
